// ===== hdl/uvseam_pkg.sv =====
package uvseam_pkg;

    localparam int FRAC_BITS_DEF  = 14;
    localparam int ANGLE_ITER_DEF = 16;

    // One result bit per square-root stage; the radicand is at scale 2^60.
    localparam int ISQ_STAGES = 31;
    localparam int ISQ_W      = 62;

    // CORDIC vector width, angle accumulator width and pre-rounding width.
    localparam int CW = 34;
    localparam int AW = 33;
    localparam int PW = 35;

    localparam logic signed [PW-1:0] HALF_TURN = PW'(64'd1 << 31);
    localparam logic signed [PW-1:0] FULL_TURN = PW'(64'd1 << 32);

    // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
    localparam logic [29:0] ATAN_TURNS [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

    // Which offset the longitude angle gets before rounding.
    typedef enum logic [1:0] {
        UB_HALF,
        UB_FULL,
        UB_NONE,
        UB_ORIGIN
    } t_ubase;

    // Clamp a turn count to the range from zero to one full turn.
    function automatic logic [32:0] turn_clamp(input logic signed [PW-1:0] a);
        logic [32:0] res;
        if (a < 0) begin
            res = '0;
        end else if (a > FULL_TURN) begin
            res = 33'(FULL_TURN);
        end else begin
            res = a[32:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/uvseam_cordic.sv =====
module uvseam_cordic
    import uvseam_pkg::*;
#(
    parameter int ITER = ANGLE_ITER_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    output logic signed [AW-1:0] o_angle
);

    logic signed [CW-1:0] r_x   [ITER-1];
    logic signed [CW-1:0] r_y   [ITER-1];
    logic signed [AW-1:0] r_acc [ITER];

    for (genvar s = 0; s < ITER; s++) begin : g_stage
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [AW-1:0] a_in;
        logic signed [AW-1:0] step;

        if (s == 0) begin : g_first
            assign x_in = i_x;
            assign y_in = i_y;
            assign a_in = '0;
        end else begin : g_next
            assign x_in = r_x[s-1];
            assign y_in = r_y[s-1];
            assign a_in = r_acc[s-1];
        end

        assign step = $signed(AW'(ATAN_TURNS[s]));

        // Rotate toward the positive x axis; the shifts round toward minus infinity.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[s] <= y_in[CW-1] ? a_in - step : a_in + step;
            end
        end

        if (s < ITER - 1) begin : g_vec
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!y_in[CW-1]) begin
                        r_x[s] <= x_in + (y_in >>> s);
                        r_y[s] <= y_in - (x_in >>> s);
                    end else begin
                        r_x[s] <= x_in - (y_in >>> s);
                        r_y[s] <= y_in + (x_in >>> s);
                    end
                end
            end
        end
    end

    assign o_angle = r_acc[ITER-1];

endmodule

// ===== hdl/uvseam_isqrt.sv =====
module uvseam_isqrt
    import uvseam_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ISQ_W-1:0]      i_rad,
    output logic [ISQ_STAGES-1:0] o_root
);

    logic [ISQ_W-1:0] r_rem  [ISQ_STAGES-1];
    logic [ISQ_W-1:0] r_root [ISQ_STAGES];

    for (genvar s = 0; s < ISQ_STAGES; s++) begin : g_stage
        localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (2 * (ISQ_STAGES - 1 - s));
        logic [ISQ_W-1:0] rem_in;
        logic [ISQ_W-1:0] root_in;
        logic [ISQ_W-1:0] trial;
        logic             take;

        if (s == 0) begin : g_first
            assign rem_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
        end

        assign trial = root_in + BIT;
        assign take  = rem_in >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[s] <= take ? (root_in >> 1) + BIT : root_in >> 1;
            end
        end

        if (s < ISQ_STAGES - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= take ? rem_in - trial : rem_in;
                end
            end
        end
    end

    assign o_root = r_root[ISQ_STAGES-1][ISQ_STAGES-1:0];

endmodule

// ===== hdl/uvseam_lane.sv =====
module uvseam_lane
    import uvseam_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int ITER      = ANGLE_ITER_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [15:0]   i_x,
    input  logic signed [15:0]   i_y,
    input  logic signed [15:0]   i_z,
    output logic [FRAC_BITS:0]   o_u,
    output logic [FRAC_BITS:0]   o_v
);

    localparam int YW = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;
    localparam int SH = 60 - 2 * FRAC_BITS;
    localparam logic signed [YW-1:0] Y_ONE = YW'(1) <<< FRAC_BITS;
    localparam logic [32:0] RND = 33'(1) << (31 - FRAC_BITS);

    // Front stage: longitude vector, latitude saturation and radicand.
    logic signed [YW-1:0]   y_ext;
    logic signed [YW-1:0]   y_sat;
    logic [2*YW-1:0]        y_sq;
    logic signed [CW-1:0]   x_w;
    logic signed [CW-1:0]   z_w;
    logic signed [CW-1:0]   n_px;
    logic signed [CW-1:0]   n_py;
    t_ubase                 n_code;

    logic [ISQ_W-1:0]       r_rad;
    logic signed [CW-1:0]   r_px;
    logic signed [CW-1:0]   r_py;
    logic signed [CW-1:0]   r_ys;
    t_ubase                 r_code;

    always_comb begin
        y_ext = YW'(i_y);
        if (y_ext > Y_ONE) begin
            y_sat = Y_ONE;
        end else if (y_ext < -Y_ONE) begin
            y_sat = -Y_ONE;
        end else begin
            y_sat = y_ext;
        end
        y_sq = $unsigned((2*YW)'(y_sat) * (2*YW)'(y_sat));

        x_w = CW'(i_x);
        z_w = CW'(i_z);
        if (i_x == 16'sd0 && i_z == 16'sd0) begin
            n_px   = '0;
            n_py   = '0;
            n_code = UB_ORIGIN;
        end else if (i_z < 0) begin
            n_px   = (-z_w) <<< 16;
            n_py   = (-x_w) <<< 16;
            n_code = (i_x >= 0) ? UB_FULL : UB_NONE;
        end else begin
            n_px   = z_w <<< 16;
            n_py   = x_w <<< 16;
            n_code = UB_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= (ISQ_W'(1) << 60) - (ISQ_W'(y_sq) << SH);
            r_ys   <= CW'(y_sat) <<< (30 - FRAC_BITS);
            r_px   <= n_px;
            r_py   <= n_py;
            r_code <= n_code;
        end
    end

    // Square root of one minus y squared.
    logic [ISQ_STAGES-1:0] root;

    uvseam_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rad  (r_rad),
        .o_root (root)
    );

    // Everything else waits for the square root.
    logic signed [CW-1:0] r_d_px   [ISQ_STAGES];
    logic signed [CW-1:0] r_d_py   [ISQ_STAGES];
    logic signed [CW-1:0] r_d_ys   [ISQ_STAGES];
    t_ubase               r_d_code [ISQ_STAGES];
    t_ubase               r_c_code [ITER];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_px[0]   <= r_px;
            r_d_py[0]   <= r_py;
            r_d_ys[0]   <= r_ys;
            r_d_code[0] <= r_code;
            for (int k = 1; k < ISQ_STAGES; k++) begin
                r_d_px[k]   <= r_d_px[k-1];
                r_d_py[k]   <= r_d_py[k-1];
                r_d_ys[k]   <= r_d_ys[k-1];
                r_d_code[k] <= r_d_code[k-1];
            end
            r_c_code[0] <= r_d_code[ISQ_STAGES-1];
            for (int k = 1; k < ITER; k++) begin
                r_c_code[k] <= r_c_code[k-1];
            end
        end
    end

    logic signed [AW-1:0] ang_u;
    logic signed [AW-1:0] ang_v;

    uvseam_cordic #(.ITER(ITER)) u_cordic_u (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_x     (r_d_px[ISQ_STAGES-1]),
        .i_y     (r_d_py[ISQ_STAGES-1]),
        .o_angle (ang_u)
    );

    uvseam_cordic #(.ITER(ITER)) u_cordic_v (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_x     ($signed(CW'(root))),
        .i_y     (r_d_ys[ISQ_STAGES-1]),
        .o_angle (ang_v)
    );

    // Offset, clamp and round to the output grid.
    logic signed [PW-1:0] base;
    logic signed [PW-1:0] u_pre;
    logic signed [PW-1:0] v_pre;
    logic [32:0]          u_rnd;
    logic [32:0]          v_rnd;

    always_comb begin
        unique case (r_c_code[ITER-1])
            UB_HALF, UB_ORIGIN: base = HALF_TURN;
            UB_FULL:            base = FULL_TURN;
            UB_NONE:            base = '0;
            default:            base = HALF_TURN;
        endcase
        u_pre = (r_c_code[ITER-1] == UB_ORIGIN) ? base : base + PW'(ang_u);
        v_pre = (PW'(ang_v) <<< 1) + HALF_TURN;
        u_rnd = turn_clamp(u_pre) + RND;
        v_rnd = turn_clamp(v_pre) + RND;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_u <= u_rnd[32:32-FRAC_BITS];
            o_v <= v_rnd[32:32-FRAC_BITS];
        end
    end

endmodule

// ===== hdl/spherical_uv_seam_fix.sv =====
// Throughput: one triangle per clock while no result is held; each vertex lane is a fully
// pipelined square root (31 stages) followed by two CORDIC pipelines of ANGLE_ITERATIONS stages each.
// The whole pipeline advances together and holds while a finished result is not taken.
// Reset clears the valid flags of every stage and the output; data registers are not reset.
module spherical_uv_seam_fix
    import uvseam_pkg::*;
#(
    parameter int FRAC_BITS        = FRAC_BITS_DEF,
    parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_ax,
    input  logic signed [15:0] i_ay,
    input  logic signed [15:0] i_az,
    input  logic signed [15:0] i_bx,
    input  logic signed [15:0] i_by_coord,
    input  logic signed [15:0] i_bz,
    input  logic signed [15:0] i_cx,
    input  logic signed [15:0] i_cy,
    input  logic signed [15:0] i_cz,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [14:0]        o_u_first,
    output logic [14:0]        o_v_first,
    output logic signed [15:0] o_u_second,
    output logic [14:0]        o_v_second,
    output logic signed [15:0] o_u_third,
    output logic [14:0]        o_v_third
);

    // Stages inside a vertex lane: front stage, square root, CORDIC, rounding.
    localparam int LANE_LAT = ANGLE_ITERATIONS + ISQ_STAGES + 2;
    localparam int SW       = FRAC_BITS + 3;

    // Seam thresholds in output units.
    localparam logic signed [SW-1:0] ONE  = SW'(1) <<< FRAC_BITS;
    localparam logic signed [SW-1:0] Q    = SW'(3) <<< (FRAC_BITS - 2);
    localparam logic signed [SW-1:0] U_LO = -(SW'(1) <<< (FRAC_BITS - 2));
    localparam logic signed [SW-1:0] U_HI = ONE + Q;

    // A single enable moves every stage; the output register frees the pipe
    // as soon as downstream takes its item.
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    logic [LANE_LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_vld   <= {r_vld[LANE_LAT-2:0], i_valid};
            o_valid <= r_vld[LANE_LAT-1];
        end
    end

    // Three identical lanes, one per vertex.
    logic [FRAC_BITS:0] u0, v0, u1, v1, u2, v2;

    uvseam_lane #(.FRAC_BITS(FRAC_BITS), .ITER(ANGLE_ITERATIONS)) u_lane_a (
        .i_clk (i_clk), .i_en (en),
        .i_x (i_ax), .i_y (i_ay), .i_z (i_az),
        .o_u (u0), .o_v (v0)
    );

    uvseam_lane #(.FRAC_BITS(FRAC_BITS), .ITER(ANGLE_ITERATIONS)) u_lane_b (
        .i_clk (i_clk), .i_en (en),
        .i_x (i_bx), .i_y (i_by_coord), .i_z (i_bz),
        .o_u (u1), .o_v (v1)
    );

    uvseam_lane #(.FRAC_BITS(FRAC_BITS), .ITER(ANGLE_ITERATIONS)) u_lane_c (
        .i_clk (i_clk), .i_en (en),
        .i_x (i_cx), .i_y (i_cy), .i_z (i_cz),
        .o_u (u2), .o_v (v2)
    );

    // Merge: a u that crosses the three-quarter line against its predecessor is
    // moved by one whole turn so the triangle does not wrap around the sphere.
    // The third vertex is checked against the already corrected second one.
    function automatic logic signed [SW-1:0] seam_fix(input logic signed [SW-1:0] cur,
                                                       input logic signed [SW-1:0] prev);
        logic signed [SW-1:0] res;
        if (cur < Q && prev > Q) begin
            res = cur + ONE;
        end else if (cur > Q && prev < Q) begin
            res = cur - ONE;
        end else begin
            res = cur;
        end
        return res;
    endfunction

    logic signed [SW-1:0] n_u1;
    logic signed [SW-1:0] n_u2;

    always_comb begin
        n_u1 = seam_fix($signed(SW'(u1)), $signed(SW'(u0)));
        n_u2 = seam_fix($signed(SW'(u2)), n_u1);
    end

    logic [FRAC_BITS:0]   r_u0, r_v0, r_v1, r_v2;
    logic signed [SW-1:0] r_u1, r_u2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u0 <= u0;
            r_v0 <= v0;
            r_u1 <= n_u1;
            r_v1 <= v1;
            r_u2 <= n_u2;
            r_v2 <= v2;
        end
    end

    assign o_u_first  = 15'(r_u0);
    assign o_v_first  = 15'(r_v0);
    assign o_u_second = 16'(r_u1);
    assign o_v_second = 15'(r_v1);
    assign o_u_third  = 16'(r_u2);
    assign o_v_third  = 15'(r_v2);

    // Nothing leaves the block in the cycle after reset.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Uncorrected coordinates of the first vertex never exceed one turn.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_u0 <= ONE[FRAC_BITS:0]) && (r_v0 <= ONE[FRAC_BITS:0]))
        else $error("first vertex coordinate beyond one");

    // A corrected u stays within a quarter turn below zero and above three quarters plus one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_u1 >= U_LO) && (r_u1 <= U_HI) && (r_u2 >= U_LO) && (r_u2 <= U_HI))
        else $error("seam correction out of range");

    // A stalled result is held by the shared enable.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(r_u1) && $stable(r_u2) && $stable(r_v0))
        else $error("result changed while stalled");

endmodule

// ===== tb/sv/spherical_uv_seam_fix_test.sv =====
`timescale 1ns / 100ps

module spherical_uv_seam_fix_test;

    localparam int LATENCY     = 50;
    localparam int N_RANDOM    = 1430;
    localparam int CYCLE_LIMIT = 400000;
    localparam int FB          = 14;
    localparam int ITERS       = 16;

    localparam longint HALF_T = 64'sd1 <<< 31;
    localparam longint FULL_T = 64'sd1 <<< 32;

    // The first 16 entries of the block's angle table: atan(2^-i) in 2^-32 turn.
    localparam longint ATAN_T [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861
    };

    typedef struct packed {
        logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    } tri_t;

    typedef struct packed {
        logic [14:0]        u0;
        logic [14:0]        v0;
        logic signed [15:0] u1;
        logic [14:0]        v1;
        logic signed [15:0] u2;
        logic [14:0]        v2;
    } uv_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic signed [15:0] i_ax = '0, i_ay = '0, i_az = '0;
    logic signed [15:0] i_bx = '0, i_by_coord = '0, i_bz = '0;
    logic signed [15:0] i_cx = '0, i_cy = '0, i_cz = '0;
    logic o_ready, o_valid;
    logic [14:0] o_u_first, o_v_first, o_v_second, o_v_third;
    logic signed [15:0] o_u_second, o_u_third;

    spherical_uv_seam_fix uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_ax(i_ax), .i_ay(i_ay), .i_az(i_az),
        .i_bx(i_bx), .i_by_coord(i_by_coord), .i_bz(i_bz),
        .i_cx(i_cx), .i_cy(i_cy), .i_cz(i_cz),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_u_first(o_u_first), .o_v_first(o_v_first),
        .o_u_second(o_u_second), .o_v_second(o_v_second),
        .o_u_third(o_u_third), .o_v_third(o_v_third)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor of the texture coordinates.
    // ---------------------------------------------------------------

    // Arithmetic right shift that rounds toward minus infinity.
    function automatic longint shr_floor(longint v, int n);
        return v >>> n;
    endfunction

    // Vectoring CORDIC angle of (px, py), px >= 0, in 2^-32 turn.
    function automatic longint vec_angle(longint px, longint py);
        longint acc, dx, dy;
        acc = 0;
        for (int i = 0; i < ITERS; i++) begin
            dx = shr_floor(py, i);
            dy = shr_floor(px, i);
            if (py >= 0) begin
                px += dx;
                py -= dy;
                acc += ATAN_T[i];
            end else begin
                px -= dx;
                py += dy;
                acc -= ATAN_T[i];
            end
        end
        return acc;
    endfunction

    function automatic longint round_turn(longint t);
        if (t < 0) t = 0;
        if (t > FULL_T) t = FULL_T;
        return (t + (64'sd1 <<< (31 - FB))) >>> (32 - FB);
    endfunction

    function automatic longint longitude(longint x, longint z);
        longint a;
        if (x == 0 && z == 0) begin
            a = 0;
        end else if (z < 0) begin
            a = vec_angle(-z * 65536, -x * 65536) + ((x >= 0) ? HALF_T : -HALF_T);
        end else begin
            a = vec_angle(z * 65536, x * 65536);
        end
        return round_turn(a + HALF_T);
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint latitude(longint y);
        longint one, ys, cs;
        one = 64'sd1 <<< FB;
        if (y > one) y = one;
        if (y < -one) y = -one;
        ys = y * (64'sd1 <<< (30 - FB));
        cs = int_sqrt(longint'(64'd1 << 60) - ys * ys);
        return round_turn(2 * vec_angle(cs, ys) + HALF_T);
    endfunction

    // Pull u across the longitude seam toward the previous vertex.
    function automatic longint seam_adjust(longint cur, longint prev);
        longint q;
        q = 64'sd3 <<< (FB - 2);
        if (cur < q && prev > q) return cur + (64'sd1 <<< FB);
        if (cur > q && prev < q) return cur - (64'sd1 <<< FB);
        return cur;
    endfunction

    function automatic uv_t predict_uv(tri_t t);
        uv_t r;
        longint ua, ub, uc;
        ua = longitude(t.ax, t.az);
        ub = seam_adjust(longitude(t.bx, t.bz), ua);
        uc = seam_adjust(longitude(t.cx, t.cz), ub);
        r.u0 = 15'(ua);
        r.v0 = 15'(latitude(t.ay));
        r.u1 = 16'(ub);
        r.v1 = 15'(latitude(t.by));
        r.u2 = 16'(uc);
        r.v2 = 15'(latitude(t.cy));
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Directed triangles. Rows with a typed-in result use fixed values
    // that are obvious from the mapping: the poles, the origin and the
    // saturation of y. The rest are checked against the predictor.
    // ---------------------------------------------------------------
    typedef struct {
        tri_t t;
        bit   typed;
        uv_t  r;
    } row_t;

    localparam logic signed [15:0] P1 = 16'sd16384;
    localparam logic signed [15:0] M1 = -16'sd16384;

    row_t dir_rows [$];
    uv_t  expected_uv [$];
    int   n_fail = 0;
    int   n_mismatch = 0;
    int   n_sent = 0;
    int   n_got = 0;
    int   cycle_count = 0;
    bit   quiet = 1'b0;
    bit   hold_long = 1'b0;

    function automatic tri_t mk(int a0, int a1, int a2, int b0, int b1, int b2,
                                int c0, int c1, int c2);
        tri_t t;
        t = '{16'(a0), 16'(a1), 16'(a2), 16'(b0), 16'(b1), 16'(b2),
              16'(c0), 16'(c1), 16'(c2)};
        return t;
    endfunction

    function automatic void add_row(tri_t t);
        row_t r;
        r.t = t;
        r.typed = 1'b0;
        r.r = '0;
        dir_rows.push_back(r);
    endfunction

    task automatic build_directed();
        row_t r;
        // All three vertices at the origin: u is one half; y of zero gives v of one half.
        r.t = mk(0, 0, 0, 0, 0, 0, 0, 0, 0);
        r.typed = 1'b1;
        r.r = '{15'd8192, 15'd8192, 16'sd8192, 15'd8192, 16'sd8192, 15'd8192};
        dir_rows.push_back(r);
        // Origin in x and z with the poles in y: v goes to one and zero.
        r.t = mk(0, 16384, 0, 0, -16384, 0, 0, 16384, 0);
        r.r = '{15'd8192, 15'd16384, 16'sd8192, 15'd0, 16'sd8192, 15'd16384};
        dir_rows.push_back(r);
        // y beyond the unit range saturates at the poles.
        r.t = mk(0, 32767, 0, 0, -32768, 0, 0, 20000, 0);
        r.r = '{15'd8192, 15'd16384, 16'sd8192, 15'd0, 16'sd8192, 15'd16384};
        dir_rows.push_back(r);
        // Back meridian, both x signs, seam crossing, axis extremes.
        add_row(mk(0, 0, M1, 0, 0, P1, 0, 0, M1));
        add_row(mk(-1, 0, M1, 1, 0, M1, -1, 0, M1));
        add_row(mk(P1, 0, 0, M1, 0, 0, 0, 0, P1));
        add_row(mk(M1, 0, 0, P1, 0, 0, M1, 0, 0));
        add_row(mk(32767, 32767, 32767, -32768, -32768, -32768, 32767, 0, -32768));
        add_row(mk(-32768, 1, 32767, 32767, -1, -32768, -32768, 0, 0));
        add_row(mk(-11585, 11585, -11585, 11585, -11585, -11585, -11585, 0, 11585));
        add_row(mk(-16383, 100, -50, 1, 16383, -16384, -2, -16383, -16384));
        add_row(mk(-16384, 0, 1, 16384, 0, 1, 16384, 0, -1));
        add_row(mk(-8192, 0, -8192, 8192, 0, 8192, -8192, 0, -8192));
        add_row(mk(16'h5555, 16'h2AAA, 16'hAAAA, 16'hD555, 16'h7FFF, 16'h8000,
                   16'h0001, 16'hFFFF, 16'h00FF));
    endtask

    function automatic logic signed [15:0] rnd_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 16'($urandom);
        if (k == 1) return 16'($urandom_range(0, 4)) - 16'sd2;
        if (k == 2) return ($urandom_range(0, 1)) ? P1 : M1;
        return 16'($urandom_range(0, 32768)) - 16'sd16384;
    endfunction

    // Random triangle, clustered near the back meridian one time in three so that seam cases are frequent.
    function automatic tri_t rnd_tri();
        tri_t t;
        t = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
              rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
        if ($urandom_range(0, 2) == 0) begin
            // Vertices near the back meridian, straddling the seam.
            t.az = -16'sd16000 + 16'($urandom_range(0, 600));
            t.bz = -16'sd16000 + 16'($urandom_range(0, 600));
            t.cz = -16'sd16000 + 16'($urandom_range(0, 600));
            t.ax = 16'($urandom_range(0, 4000)) - 16'sd2000;
            t.bx = 16'($urandom_range(0, 4000)) - 16'sd2000;
            t.cx = 16'($urandom_range(0, 4000)) - 16'sd2000;
        end
        return t;
    endfunction

    task automatic send_tri(tri_t t);
        i_valid    <= 1'b1;
        i_ax       <= t.ax; i_ay <= t.ay; i_az <= t.az;
        i_bx       <= t.bx; i_by_coord <= t.by; i_bz <= t.bz;
        i_cx       <= t.cx; i_cy <= t.cy; i_cz <= t.cz;
        do @(posedge i_clk); while (!o_ready);
        n_sent++;
    endtask

    // Random sender gap; the item after it starts a fresh valid.
    task automatic sender_gap();
        int g;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            g = $urandom_range(1, 7);
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver: random ready bursts, one long hold-off, and the checker.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && i_ready) begin
            uv_t got, exp_uv;
            got = '{o_u_first, o_v_first, o_u_second, o_v_second, o_u_third, o_v_third};
            n_got <= n_got + 1;
            if (expected_uv.size() == 0) begin
                n_fail++;
                $display("unexpected result %p", got);
            end else begin
                exp_uv = expected_uv.pop_front();
                if (got !== exp_uv) begin
                    n_fail++;
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected %p, got %p", exp_uv, got);
                end
            end
        end
    end

    initial begin
        int g;
        @(posedge i_clk);
        forever begin
            if (hold_long) begin
                i_ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_long = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                g = $urandom_range(1, 7);
                i_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        @(posedge i_clk);
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("[spherical_uv_seam_fix] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence.
    // ---------------------------------------------------------------
    initial begin
        tri_t t;
        uv_t  p;
        build_directed();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            p = predict_uv(dir_rows[k].t);
            if (dir_rows[k].typed && p !== dir_rows[k].r) begin
                n_fail++;
                $display("predictor disagrees on directed row %0d", k);
            end
            expected_uv.push_back(dir_rows[k].typed ? dir_rows[k].r : p);
            send_tri(dir_rows[k].t);
            sender_gap();
        end

        // Sender pauses until every result is back.
        i_valid <= 1'b0;
        while (expected_uv.size() != 0) @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            // Receiver stalls for a long stretch while items keep coming.
            if (n == 300) hold_long = 1'b1;
            if (n == N_RANDOM - 200) quiet = 1'b1;
            t = rnd_tri();
            expected_uv.push_back(predict_uv(t));
            send_tri(t);
            sender_gap();
        end
        i_valid <= 1'b0;

        while (expected_uv.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("sent %0d triangles (directed and random), %0d results checked",
                 n_sent, n_got);
        $display("covered origin, poles, saturation, back meridian and seam crossings");
        if (n_fail == 0 && expected_uv.size() == 0) begin
            $display("[spherical_uv_seam_fix] OK");
        end else begin
            $display("%0d failures", n_fail);
            $display("[spherical_uv_seam_fix] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/uvseam_pkg.sv
hdl/uvseam_cordic.sv
hdl/uvseam_isqrt.sv
hdl/uvseam_lane.sv
hdl/spherical_uv_seam_fix.sv
tb/sv/spherical_uv_seam_fix_test.sv
